/* rtl/mf_pkg.sv */
// ----------------------------------------------------------------------------
// mf_pkg: shared types and constants of the message FIFO
// Sizes of the byte ring and the length ring, the payload structs, the status
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mf_pkg;

  localparam int BUFFER_BYTES  = 1024;
  localparam int MESSAGE_SLOTS = 64;
  localparam int MAX_MESSAGE   = 64;

  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int USED_W = $clog2(BUFFER_BYTES + 1);
  localparam int SLOT_W = $clog2(MESSAGE_SLOTS);
  localparam int HELD_W = $clog2(MESSAGE_SLOTS + 1);
  localparam int LEN_W  = $clog2(MAX_MESSAGE + 1);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic [1:0] status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;
    logic pop_empty;
    logic pop_start;
    logic pop_byte;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic queue_empty;
    logic pop_last;
  } dp_sts_t;

  function automatic logic [PTR_W-1:0] next_byte_pos(input logic [PTR_W-1:0] p);
    next_byte_pos = (p == PTR_W'(BUFFER_BYTES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    next_slot = (p == SLOT_W'(MESSAGE_SLOTS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

endpackage

/* rtl/mf_ctrl.sv */
// ----------------------------------------------------------------------------
// mf_ctrl: message FIFO controller
// Decides when an input transaction is taken and steps through a pop stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            action_i,
  output logic            in_stall_o,
  input  mf_pkg::dp_sts_t sts_i,
  output mf_pkg::dp_cmd_t cmd_o
);
  import mf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_PUSH) begin
            cmd_o.push = 1'b1;
          end else if (sts_i.queue_empty) begin
            cmd_o.pop_empty = 1'b1;
          end else begin
            cmd_o.pop_start = 1'b1;
            state_d         = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        // One message byte leaves each cycle the output register has room.
        if (sts_i.out_free) begin
          cmd_o.pop_byte = 1'b1;
          if (sts_i.pop_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/mf_datapath.sv */
// ----------------------------------------------------------------------------
// mf_datapath: message FIFO rings, pointers and output register
// Holds the byte ring, the length ring, their pointers and counts, and the
// registered result that parts the input side from the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mf_pkg::in_item_t  in_item_i,
  input  mf_pkg::dp_cmd_t   cmd_i,
  output mf_pkg::dp_sts_t   sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mf_pkg::out_item_t out_item_o
);
  import mf_pkg::*;

  logic [7:0]       byte_mem [BUFFER_BYTES];
  logic [LEN_W-1:0] len_mem  [MESSAGE_SLOTS];

  logic [PTR_W-1:0]  byte_head_q, byte_head_d;
  logic [PTR_W-1:0]  byte_tail_q, byte_tail_d;
  logic [PTR_W-1:0]  msg_start_q, msg_start_d;
  logic [USED_W-1:0] bytes_used_q, bytes_used_d;
  logic [SLOT_W-1:0] len_head_q, len_head_d;
  logic [SLOT_W-1:0] len_tail_q, len_tail_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [LEN_W-1:0]  cur_len_q, cur_len_d;
  status_e           drop_q, drop_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic              out_load;

  logic [7:0]        rd_byte_q;
  logic [LEN_W-1:0]  rd_len_q;

  logic              byte_wr;
  logic              len_wr;
  status_e           drop_new;
  logic [PTR_W-1:0]  tail_new;
  logic [LEN_W-1:0]  cur_new;
  logic [LEN_W-1:0]  len_cap;
  logic [LEN_W-1:0]  len_eff;
  logic              pop_last;

  // The stored length is bounded by the largest message and the bytes held.
  assign len_cap  = (rd_len_q > LEN_W'(MAX_MESSAGE)) ? LEN_W'(MAX_MESSAGE) : rd_len_q;
  assign len_eff  = (USED_W'(len_cap) > bytes_used_q) ? LEN_W'(bytes_used_q) : len_cap;
  assign pop_last = ({1'b0, cnt_q} + (LEN_W + 1)'(1)) == {1'b0, len_eff};

  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.queue_empty = (held_q == '0);
  assign sts_o.pop_last    = pop_last;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    byte_head_d  = byte_head_q;
    byte_tail_d  = byte_tail_q;
    msg_start_d  = msg_start_q;
    bytes_used_d = bytes_used_q;
    len_head_d   = len_head_q;
    len_tail_d   = len_tail_q;
    held_d       = held_q;
    cur_len_d    = cur_len_q;
    drop_d       = drop_q;
    cnt_d        = cnt_q;
    byte_wr      = 1'b0;
    len_wr       = 1'b0;
    out_load     = 1'b0;
    out_item_d   = out_item_q;
    drop_new     = drop_q;
    tail_new     = byte_tail_q;
    cur_new      = cur_len_q;

    if (cmd_i.push) begin
      if (drop_q == ST_OK) begin
        if (cur_len_q >= LEN_W'(MAX_MESSAGE)) begin
          drop_new = ST_LONG;
        end else if (({1'b0, bytes_used_q} + (USED_W + 1)'(cur_len_q))
                     >= (USED_W + 1)'(BUFFER_BYTES) ||
                     held_q >= HELD_W'(MESSAGE_SLOTS)) begin
          drop_new = ST_FULL;
        end else begin
          byte_wr  = 1'b1;
          tail_new = next_byte_pos(byte_tail_q);
          cur_new  = cur_len_q + LEN_W'(1);
        end
      end
      if (in_item_i.last_byte) begin
        out_load              = 1'b1;
        out_item_d.out_byte   = '0;
        out_item_d.end_of_run = 1'b1;
        out_item_d.status     = drop_new;
        if (drop_new == ST_OK) begin
          len_wr       = 1'b1;
          len_tail_d   = next_slot(len_tail_q);
          held_d       = held_q + HELD_W'(1);
          bytes_used_d = bytes_used_q + USED_W'(cur_new);
          byte_tail_d  = tail_new;
          msg_start_d  = tail_new;
        end else begin
          // A faulty message is dropped whole: the tail returns to its start.
          byte_tail_d = msg_start_q;
          msg_start_d = msg_start_q;
        end
        cur_len_d = '0;
        drop_d    = ST_OK;
      end else begin
        byte_tail_d = tail_new;
        cur_len_d   = cur_new;
        drop_d      = drop_new;
      end
    end

    if (cmd_i.pop_empty) begin
      out_load              = 1'b1;
      out_item_d.out_byte   = '0;
      out_item_d.end_of_run = 1'b1;
      out_item_d.status     = ST_EMPTY;
    end

    if (cmd_i.pop_start) begin
      cnt_d = '0;
    end

    if (cmd_i.pop_byte) begin
      out_load              = 1'b1;
      out_item_d.out_byte   = rd_byte_q;
      out_item_d.end_of_run = pop_last;
      out_item_d.status     = ST_OK;
      byte_head_d           = next_byte_pos(byte_head_q);
      cnt_d                 = cnt_q + LEN_W'(1);
      if (pop_last) begin
        len_head_d   = next_slot(len_head_q);
        held_d       = held_q - HELD_W'(1);
        bytes_used_d = bytes_used_q - USED_W'(len_eff);
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_head_q  <= '0;
      byte_tail_q  <= '0;
      msg_start_q  <= '0;
      bytes_used_q <= '0;
      len_head_q   <= '0;
      len_tail_q   <= '0;
      held_q       <= '0;
      cur_len_q    <= '0;
      drop_q       <= ST_OK;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_head_q  <= byte_head_d;
      byte_tail_q  <= byte_tail_d;
      msg_start_q  <= msg_start_d;
      bytes_used_q <= bytes_used_d;
      len_head_q   <= len_head_d;
      len_tail_q   <= len_tail_d;
      held_q       <= held_d;
      cur_len_q    <= cur_len_d;
      drop_q       <= drop_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  // Both rings are read at the next head every cycle, so the read data
  // always belongs to the current head.
  always_ff @(posedge clk_i) begin
    if (byte_wr) begin
      byte_mem[byte_tail_q] <= in_item_i.data_byte;
    end
    rd_byte_q <= byte_mem[byte_head_d];
  end

  always_ff @(posedge clk_i) begin
    if (len_wr) begin
      len_mem[len_tail_q] <= cur_new;
    end
    rd_len_q <= len_mem[len_head_d];
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HELD_W'(MESSAGE_SLOTS))
    else $error("message count exceeds the number of slots");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_used_q <= USED_W'(BUFFER_BYTES))
    else $error("committed bytes exceed the ring size");

  a_empty_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (bytes_used_q == '0))
    else $error("bytes held with no committed message");

  a_pop_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_byte && pop_last) |=> (held_q == $past(held_q) - HELD_W'(1)))
    else $error("finished pop did not retire one message");

endmodule

/* rtl/message_fifo.sv */
// ----------------------------------------------------------------------------
// message_fifo: queue of variable-length byte messages
// A push or empty-pop result is in the output register in the cycle after its
// transaction is taken; a popped message's first byte follows the start step.
// One push byte per cycle while the output register has room; a pop holds the
// input to start and to move each byte, longer while the output stalls. Reset
// clears the states, pointers, counts and valid flag; the rings need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A push transaction carries one message byte. Bytes go straight into the byte
// ring at the tail pointer; the last byte of a message produces one status
// transaction (ok, full or too long). A message that breaks either limit is
// dropped whole by returning the tail pointer to where the message began.
//
// A pop transaction either answers with a single empty status, or streams
// the oldest message. The stream is paced by the single read port of the
// byte ring, which is read at the next head address every cycle, so the byte
// at the head is ready in the same cycle the head moves there. No new
// transaction is taken until the last byte of the message has entered the
// output register.
//
// The output register decouples the two sides: an input transaction is taken
// whenever the controller is idle and the register is empty or is being drained in the same cycle.

module message_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mf_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mf_pkg::out_item_t out_item_o
);
  import mf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences transactions; of the input item it sees only the action bit.
  mf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_item_i.action),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns both rings, all pointers and the output register.
  mf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
